// File: hw/rtl/rs2i_pkg.sv
// Shared types and constants for the radix string to integer converter.
package rs2i_pkg;

    localparam int CHAR_W  = 8;
    localparam int BASE_W  = 6;
    localparam int DIGIT_W = 6;
    localparam int VALUE_W = 31;
    localparam int PROD_W  = VALUE_W + BASE_W;
    localparam int CFG_W   = 8;
    localparam int OUT_W   = 40;

    localparam logic [BASE_W-1:0] BASE_MIN     = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX     = BASE_W'(36);
    localparam logic [BASE_W-1:0] BASE_DEFAULT = BASE_W'(10);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        CFG_RADIX       = 1'b0,
        CFG_LETTER_CASE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] value;
    } t_digit;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
    } t_result;

endpackage

// File: hw/rtl/rs2i_digit.sv
// Character to digit decoder with base and letter case check.
module rs2i_digit
    import rs2i_pkg::*;
(
    input  logic [CHAR_W-1:0] i_char,
    input  logic [BASE_W-1:0] i_base,
    input  logic              i_upper,
    output t_digit            o_digit
);

    logic               is_num;
    logic               alpha_up;
    logic               alpha_low;
    logic [DIGIT_W-1:0] raw;
    logic               ok_class;

    always_comb begin
        is_num    = (i_char >= 8'h30) && (i_char <= 8'h39);
        alpha_up  = (i_char >= 8'h41) && (i_char <= 8'h5a);
        alpha_low = (i_char >= 8'h61) && (i_char <= 8'h7a);
        raw       = '0;
        ok_class  = 1'b0;
        if (is_num) begin
            raw      = DIGIT_W'(i_char - 8'h30);
            ok_class = 1'b1;
        end else if (alpha_up) begin
            raw      = DIGIT_W'(i_char - 8'h41 + 8'd10);
            ok_class = i_upper;
        end else if (alpha_low) begin
            raw      = DIGIT_W'(i_char - 8'h61 + 8'd10);
            ok_class = !i_upper;
        end
        o_digit.value = raw;
        o_digit.valid = ok_class && (raw < i_base);
    end

endmodule

// File: hw/rtl/rs2i_accum.sv
// Accumulator state and multiply-add for one digit per cycle in which i_advance is high.
module rs2i_accum
    import rs2i_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_last,
    input  t_digit            i_digit,
    input  logic [BASE_W-1:0] i_base,
    output t_result           o_result
);

    logic [VALUE_W-1:0] r_acc;
    logic               r_ovf;
    logic               r_inv;
    logic [VALUE_W-1:0] n_acc;
    logic               n_ovf;
    logic               n_inv;
    logic [PROD_W-1:0]  prod;

    always_comb begin
        prod  = PROD_W'(r_acc) * PROD_W'(i_base) + PROD_W'(i_digit.value);
        n_acc = r_acc;
        n_ovf = r_ovf;
        n_inv = r_inv;
        if (!i_digit.valid) begin
            // invalid character restarts the digit run
            n_acc = '0;
            n_ovf = 1'b0;
            n_inv = 1'b1;
        end else if (!r_ovf) begin
            if (prod[PROD_W-1:VALUE_W] != '0) begin
                n_ovf = 1'b1;
            end else begin
                n_acc = prod[VALUE_W-1:0];
            end
        end
    end

    always_comb begin
        if (n_ovf) begin
            o_result.value  = '0;
            o_result.status = ST_OVERFLOW;
        end else if (n_inv) begin
            o_result.value  = '0;
            o_result.status = ST_INVALID;
        end else begin
            o_result.value  = n_acc;
            o_result.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_inv <= 1'b0;
        end else if (i_advance) begin
            if (i_last) begin
                r_acc <= '0;
                r_ovf <= 1'b0;
                r_inv <= 1'b0;
            end else begin
                r_acc <= n_acc;
                r_ovf <= n_ovf;
                r_inv <= n_inv;
            end
        end
    end

endmodule

// File: hw/rtl/radix_string_to_integer_top.sv
// The last character of a string waits in the input register; its result beat is then loaded into the result register.
// Throughput: one character per cycle while no last character stalls; the digit decode and one 31x6 multiply-add
// between the input register and the accumulator set the cycle.
// A last character stalls in the input register only while an untaken result holds the output.
// Reset (synchronous, active low) clears the pipeline, the string state, and sets
// radix 10 and uppercase letters.
module radix_string_to_integer_top
    import rs2i_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] character
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // [30:0] value, [32:31] status, zero pad
);

    logic [BASE_W-1:0] r_base;
    logic              r_upper;
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              r_out_valid;
    t_result           r_out;
    logic              advance;
    logic              out_free;
    t_digit            digit;
    t_result           result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_DEFAULT;
            r_upper <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RADIX: begin
                    // fold out-of-range bases to ten at write time
                    if (i_cfg_data < CFG_W'(BASE_MIN) || i_cfg_data > CFG_W'(BASE_MAX)) begin
                        r_base <= BASE_DEFAULT;
                    end else begin
                        r_base <= i_cfg_data[BASE_W-1:0];
                    end
                end
                CFG_LETTER_CASE: begin
                    r_upper <= i_cfg_data[0];
                end
                default: begin
                    r_upper <= r_upper;
                end
            endcase
        end
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    // only a last beat needs the result register
    assign advance       = r_in_valid && (!r_last || out_free);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_char <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    rs2i_digit u_digit (
        .i_char  (r_char),
        .i_base  (r_base),
        .i_upper (r_upper),
        .o_digit (digit)
    );

    rs2i_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_last    (r_last),
        .i_digit   (digit),
        .i_base    (r_base),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out.status, r_out.value});

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.value == '0))
        else $error("nonzero value with error status");

    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_last) |=> m_axis_tvalid)
        else $error("last beat did not load a result");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_last && r_out_valid && !m_axis_tready) |-> !advance)
        else $error("last beat advanced over a pending result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !r_in_valid))
        else $error("pipeline not cleared by reset");

endmodule

// File: sim/tb_radix_string_to_integer_top.sv
// Self-checking testbench for the radix string to integer converter top level.
`timescale 1ns / 1ps

module tb_radix_string_to_integer_top;
    import rs2i_pkg::*;

    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 113;

    localparam logic [7:0] CH_0  = "0";
    localparam logic [7:0] CH_9  = "9";
    localparam logic [7:0] CH_UA = "A";
    localparam logic [7:0] CH_UZ = "Z";
    localparam logic [7:0] CH_LA = "a";
    localparam logic [7:0] CH_LZ = "z";

    localparam longint unsigned VALUE_MAX = 64'h7FFF_FFFF;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = CFG_RADIX;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [CHAR_W-1:0] s_axis_tdata = '0;    // [7:0] character
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;         // [30:0] value, [32:31] status, zero pad

    radix_string_to_integer_top dut (.*);

    always #6 i_clk = ~i_clk;

    // Mirror of the converter: registers and per-string state.
    logic [7:0]         cfg_radix = 8'd10;
    logic               cfg_upper = 1'b1;
    logic [VALUE_W-1:0] str_acc = '0;
    logic               str_overflow = 1'b0;
    logic               str_invalid = 1'b0;

    t_result pending_conversions[$];
    t_result oldest_conversion;
    int      fail_count = 0;
    int      sink_wait = 0;
    int      stall_cycles = 0;
    bit      src_idle = 1'b1;
    bit      snk_idle = 1'b1;

    function automatic int current_base();
        return (cfg_radix >= 2 && cfg_radix <= 36) ? int'(cfg_radix) : 10;
    endfunction

    function automatic logic [7:0] digit_char(input int d, input bit upper);
        if (d < 10)
            return CH_0 + 8'(d);
        return (upper ? CH_UA : CH_LA) + 8'(d - 10);
    endfunction

    // Advance the string state by one character; queue a result on the last one.
    function automatic void accumulate_char(input logic [7:0] c, input logic last);
        int              base;
        int              d;
        longint unsigned nxt;
        t_result         r;
        base = current_base();
        d = -1;
        if (c >= CH_0 && c <= CH_9)
            d = int'(c - CH_0);
        else if (c >= CH_UA && c <= CH_UZ)
            d = cfg_upper ? int'(c - CH_UA) + 10 : -1;
        else if (c >= CH_LA && c <= CH_LZ)
            d = !cfg_upper ? int'(c - CH_LA) + 10 : -1;
        if (d >= base)
            d = -1;
        if (d < 0) begin
            str_invalid = 1'b1;
            str_acc = '0;
            str_overflow = 1'b0;
        end else if (!str_overflow) begin
            nxt = longint'(str_acc) * base + d;
            if (nxt > VALUE_MAX)
                str_overflow = 1'b1;
            else
                str_acc = nxt[VALUE_W-1:0];
        end
        if (last) begin
            r.value = '0;
            if (str_overflow) begin
                r.status = ST_OVERFLOW;
            end else if (str_invalid) begin
                r.status = ST_INVALID;
            end else begin
                r.value = str_acc;
                r.status = ST_OK;
            end
            pending_conversions.push_back(r);
            str_acc = '0;
            str_overflow = 1'b0;
            str_invalid = 1'b0;
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        accumulate_char(c, last);
    endtask

    task automatic send_text(input string text);
        for (int k = 0; k < text.len(); k++)
            send_char(text[k], k == text.len() - 1);
    endtask

    // Drop valid, wait for every pending result, then let the pipeline settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_conversions.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RADIX)
            cfg_radix = data;
        else
            cfg_upper = data[0];
        @(posedge i_clk);
    endtask

    // Reset values: base 10, uppercase; NUL, a plain digit, a high byte then a digit.
    task automatic test_reset_defaults();
        send_char(8'h00, 1'b1);
        send_text("9");
        send_char(8'hFF, 1'b0);
        send_text("1");
        wait_drained();
    endtask

    // Base 36 at the top of the value range; overflow wins over an earlier bad letter.
    task automatic test_base36_limits();
        write_reg(CFG_RADIX, 8'd36);
        write_reg(CFG_LETTER_CASE, 8'd1);
        send_text("ZIK0ZJ");
        send_text("zZIK0ZK");
        wait_drained();
    endtask

    // Lowercase mode with an out-of-range base, then a base switch inside a string.
    task automatic test_lowercase_and_base_switch();
        write_reg(CFG_LETTER_CASE, 8'd0);
        write_reg(CFG_RADIX, 8'd0);
        send_text("a");
        send_char(8'h80, 1'b1);
        wait_drained();
        write_reg(CFG_RADIX, 8'd2);
        send_char("1", 1'b0);
        wait_drained();
        write_reg(CFG_RADIX, 8'd255);
        send_char("9", 1'b1);
        wait_drained();
    endtask

    function automatic logic [7:0] bad_char();
        int base;
        base = current_base();
        case ($urandom_range(0, 2))
            0: return 8'($urandom_range(0, 255));
            1: return (cfg_upper ? CH_LA : CH_UA) + 8'($urandom_range(0, 25));
            default: begin
                if (base < 36)
                    return digit_char($urandom_range(base, 35), cfg_upper);
                return 8'($urandom_range(128, 255));
            end
        endcase
    endfunction

    task automatic send_number(output int len);
        int base;
        int bad_at;
        int kind;
        int d;
        logic [7:0] c;
        base = current_base();
        kind = $urandom_range(0, 9);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 34) : $urandom_range(1, 8);
        if (kind == 9) begin
            // raw noise, last bit at random
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            bad_at = (kind >= 7) ? $urandom_range(0, len - 1) : -1;
            for (int k = 0; k < len; k++) begin
                d = ($urandom_range(0, 3) == 0) ? base - 1 : $urandom_range(0, base - 1);
                c = (k == bad_at) ? bad_char() : digit_char(d, cfg_upper);
                send_char(c, k == len - 1);
            end
        end
    endtask

    task automatic test_random_strings();
        logic [7:0] radix_set[12] = '{8'd2, 8'd36, 8'd10, 8'd16, 8'd0, 8'd1,
                                      8'd37, 8'd255, 8'd8, 8'd3, 8'd0, 8'd0};
        int sent;
        int len;
        radix_set[10] = 8'($urandom_range(0, 255));
        radix_set[11] = 8'($urandom_range(2, 36));
        foreach (radix_set[p]) begin
            write_reg(CFG_RADIX, radix_set[p]);
            write_reg(CFG_LETTER_CASE, CFG_W'(p % 2));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 15) == 0) begin
                    src_idle = $urandom_range(0, 3) != 0;
                    snk_idle = $urandom_range(0, 3) != 0;
                end
                send_number(len);
                sent += len;
            end
            wait_drained();
        end
    endtask

    // Result side: random back-pressure, compare each beat with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_conversions.size() == 0) begin
                $error("result beat with no conversion pending: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                oldest_conversion = pending_conversions.pop_front();
                if (m_axis_tdata[30:0] !== oldest_conversion.value) begin
                    $error("value: expected %0d, actual %0d",
                           oldest_conversion.value, m_axis_tdata[30:0]);
                    fail_count++;
                end
                if (m_axis_tdata[32:31] !== oldest_conversion.status) begin
                    $error("status: expected %0d, actual %0d",
                           oldest_conversion.status, m_axis_tdata[32:31]);
                    fail_count++;
                end
                if (m_axis_tdata[OUT_W-1:33] !== '0) begin
                    $error("pad: expected 0, actual %h", m_axis_tdata[OUT_W-1:33]);
                    fail_count++;
                end
            end
            sink_wait = snk_idle ? $urandom_range(0, 10) : 0;
        end
        if (sink_wait > 0) begin
            m_axis_tready <= 1'b0;
            sink_wait--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_base36_limits();
        test_lowercase_and_base_switch();
        test_random_strings();
        wait_drained();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rs2i_pkg.sv
hw/rtl/rs2i_digit.sv
hw/rtl/rs2i_accum.sv
hw/rtl/radix_string_to_integer_top.sv
sim/tb_radix_string_to_integer_top.sv
